FILE: sv/uoe_pkg.sv
package uoe_pkg;

   localparam int FlagN = 7;
   localparam int FlagV = 6;
   localparam int FlagD = 3;
   localparam int FlagZ = 1;
   localparam int FlagC = 0;

   localparam logic [7:0] MagicConst = 8'hEE;

   typedef enum logic [4:0] {
      ACT_LAX = 5'd0,
      ACT_SAX = 5'd1,
      ACT_DCP = 5'd2,
      ACT_ISB = 5'd3,
      ACT_SLO = 5'd4,
      ACT_RLA = 5'd5,
      ACT_SRE = 5'd6,
      ACT_RRA = 5'd7,
      ACT_ANC = 5'd8,
      ACT_ASR = 5'd9,
      ACT_ARR = 5'd10,
      ACT_SBX = 5'd11,
      ACT_LAS = 5'd12,
      ACT_ANE = 5'd13,
      ACT_LXA = 5'd14,
      ACT_SHA = 5'd15,
      ACT_SHX = 5'd16,
      ACT_SHY = 5'd17,
      ACT_SHS = 5'd18,
      ACT_JAM = 5'd19
   } uoe_action_type;

   typedef struct packed {
      logic [4:0]  action;
      logic [7:0]  acc;
      logic [7:0]  xreg;
      logic [7:0]  yreg;
      logic [7:0]  stack_ptr;
      logic [7:0]  status;
      logic [7:0]  operand;
      logic [15:0] addr;
   } uoe_req_type;

   typedef struct packed {
      logic [7:0] acc_out;
      logic [7:0] x_out;
      logic [7:0] sp_out;
      logic [7:0] status_out;
      logic       write_enable;
      logic [7:0] write_data;
      logic       halted;
   } uoe_rsp_type;

endpackage

FILE: sv/uoe_req_if.sv
interface uoe_req_if;
   import uoe_pkg::*;

   logic        valid;
   logic        ready;
   uoe_req_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

FILE: sv/uoe_rsp_if.sv
interface uoe_rsp_if;
   import uoe_pkg::*;

   logic        valid;
   logic        ready;
   uoe_rsp_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

FILE: sv/undocumented_opcode_execute_core.sv
// Executes one undocumented NMOS 6502 opcode per request word and returns one response word
// with the new A, X, SP and status, the optional memory write and the halt flag. A word
// accepted on req_chan is captured in an input register, evaluated in a single combinational
// pass and loaded into the result register once that register is free or being emptied; the
// response leaves on rsp_chan from the result register. A new word is accepted every cycle
// while rsp_chan keeps taking responses, and a stalled response backs up into the input
// register before req_chan.ready drops. Decimal behavior of ARR, RRA and ISB follows the D
// flag only while csr_write_data last written is 1, which is also its state after reset.
module undocumented_opcode_execute_core (
   input  logic      clock,
   input  logic      reset,
   uoe_req_if.sink   req_chan,
   uoe_rsp_if.source rsp_chan,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);
   import uoe_pkg::*;

   logic        decimal_enable_ff;
   logic        decimal_enable_in;
   logic        stage1_valid_ff;
   logic        stage1_valid_in;
   uoe_req_type stage1_word_ff;
   uoe_req_type stage1_word_in;
   logic        stage2_valid_ff;
   logic        stage2_valid_in;
   uoe_rsp_type stage2_word_ff;
   uoe_rsp_type stage2_word_in;
   uoe_rsp_type alu_word;
   logic        stage2_load;
   logic        stage1_load;

   uoe_alu u_alu (
      .req_word       (stage1_word_ff),
      .decimal_enable (decimal_enable_ff),
      .rsp_word       (alu_word)
   );

   always_comb begin
      stage2_load    = stage1_valid_ff & (~stage2_valid_ff | rsp_chan.ready);
      req_chan.ready = ~stage1_valid_ff | stage2_load;
      stage1_load    = req_chan.valid & req_chan.ready;

      decimal_enable_in = csr_write_enable ? csr_write_data : decimal_enable_ff;

      stage1_valid_in = stage1_load | (stage1_valid_ff & ~stage2_load);
      stage1_word_in  = stage1_load ? req_chan.data : stage1_word_ff;

      stage2_valid_in = stage2_load | (stage2_valid_ff & ~rsp_chan.ready);
      stage2_word_in  = stage2_load ? alu_word : stage2_word_ff;

      rsp_chan.valid = stage2_valid_ff;
      rsp_chan.data  = stage2_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimal_enable_ff <= 1'b1;
         stage1_valid_ff   <= 1'b0;
         stage2_valid_ff   <= 1'b0;
      end else begin
         decimal_enable_ff <= decimal_enable_in;
         stage1_valid_ff   <= stage1_valid_in;
         stage2_valid_ff   <= stage2_valid_in;
      end
      stage1_word_ff <= stage1_word_in;
      stage2_word_ff <= stage2_word_in;
   end

endmodule

FILE: sv/uoe_alu.sv
module uoe_alu (
   input  uoe_pkg::uoe_req_type req_word,
   input  logic                 decimal_enable,
   output uoe_pkg::uoe_rsp_type rsp_word
);
   import uoe_pkg::*;

   // Returns {status, result}.
   function automatic logic [15:0] adc_op(input logic [7:0] a, input logic [7:0] m,
                                          input logic [7:0] p, input logic bcd);
      logic [8:0] bin;
      logic [4:0] lo;
      logic [9:0] t;
      logic [7:0] q;
      logic [7:0] res;
      q   = p;
      bin = {1'b0, a} + {1'b0, m} + {8'd0, p[FlagC]};
      if (!bcd) begin
         res      = bin[7:0];
         q[FlagN] = res[7];
         q[FlagZ] = (res == 8'd0);
         q[FlagC] = bin[8];
         q[FlagV] = ~(a[7] ^ m[7]) & (a[7] ^ bin[7]);
      end else begin
         lo = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, p[FlagC]};
         if (lo >= 5'd10) begin
            lo = {1'b1, lo[3:0] + 4'd6};
         end
         t = {2'd0, a[7:4], 4'd0} + {2'd0, m[7:4], 4'd0} + {5'd0, lo};
         q[FlagZ] = (bin[7:0] == 8'd0);
         q[FlagN] = t[7];
         q[FlagV] = ~(a[7] ^ m[7]) & (a[7] ^ t[7]);
         if (t >= 10'h0A0) begin
            t = t + 10'h060;
         end
         q[FlagC] = (t >= 10'h100);
         res      = t[7:0];
      end
      return {q, res};
   endfunction

   // Flags always come from the binary difference.
   function automatic logic [15:0] sbc_op(input logic [7:0] a, input logic [7:0] m,
                                          input logic [7:0] p, input logic bcd);
      logic [8:0] bin;
      logic [5:0] lo;
      logic [5:0] lo_adj;
      logic [9:0] t;
      logic [7:0] q;
      logic [7:0] res;
      q        = p;
      bin      = {1'b0, a} - {1'b0, m} - {8'd0, ~p[FlagC]};
      res      = bin[7:0];
      q[FlagN] = res[7];
      q[FlagZ] = (res == 8'd0);
      q[FlagC] = ({1'b0, a} + {8'd0, p[FlagC]}) > {1'b0, m};
      q[FlagV] = (a[7] ^ m[7]) & (a[7] ^ res[7]);
      if (bcd) begin
         lo     = {2'd0, a[3:0]} - {2'd0, m[3:0]} + {5'd0, p[FlagC]} - 6'd1;
         lo_adj = lo - 6'd6;
         t      = {2'd0, a[7:4], 4'd0} - {2'd0, m[7:4], 4'd0};
         if (lo[5]) begin
            t = t + {6'd0, lo_adj[3:0]} - 10'd16;
         end else begin
            t = t + {4'd0, lo};
         end
         if (t[9]) begin
            t = t - 10'd96;
         end
         res = t[7:0];
      end
      return {q, res};
   endfunction

   logic [7:0]  a;
   logic [7:0]  x;
   logic [7:0]  sp;
   logic [7:0]  p;
   logic [7:0]  m;
   logic [7:0]  hi;
   logic [7:0]  v;
   logic [7:0]  t;
   logic [7:0]  diff;
   logic [15:0] arith;
   logic        bcd;
   logic        we;
   logic [7:0]  wd;
   logic        halt;

   always_comb begin
      a     = req_word.acc;
      x     = req_word.xreg;
      sp    = req_word.stack_ptr;
      p     = req_word.status;
      m     = req_word.operand;
      hi    = req_word.addr[15:8] + 8'd1;
      bcd   = decimal_enable & req_word.status[FlagD];
      we    = 1'b0;
      wd    = 8'd0;
      halt  = 1'b0;
      v     = 8'd0;
      t     = 8'd0;
      diff  = 8'd0;
      arith = 16'd0;
      case (req_word.action)
         ACT_LAX: begin
            a = m;
            x = m;
            p[FlagN] = m[7];
            p[FlagZ] = (m == 8'd0);
         end
         ACT_SAX: begin
            we = 1'b1;
            wd = a & x;
         end
         ACT_DCP: begin
            v        = m - 8'd1;
            we       = 1'b1;
            wd       = v;
            diff     = a - v;
            p[FlagC] = (a >= v);
            p[FlagN] = diff[7];
            p[FlagZ] = (diff == 8'd0);
         end
         ACT_ISB: begin
            v     = m + 8'd1;
            we    = 1'b1;
            wd    = v;
            arith = sbc_op(a, v, p, bcd);
            p     = arith[15:8];
            a     = arith[7:0];
         end
         ACT_SLO: begin
            p[FlagC] = m[7];
            v        = {m[6:0], 1'b0};
            we       = 1'b1;
            wd       = v;
            a        = a | v;
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
         end
         ACT_RLA: begin
            v        = {m[6:0], p[FlagC]};
            p[FlagC] = m[7];
            we       = 1'b1;
            wd       = v;
            a        = a & v;
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
         end
         ACT_SRE: begin
            p[FlagC] = m[0];
            v        = {1'b0, m[7:1]};
            we       = 1'b1;
            wd       = v;
            a        = a ^ v;
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
         end
         ACT_RRA: begin
            v        = {p[FlagC], m[7:1]};
            p[FlagC] = m[0];
            we       = 1'b1;
            wd       = v;
            arith    = adc_op(a, v, p, bcd);
            p        = arith[15:8];
            a        = arith[7:0];
         end
         ACT_ANC: begin
            a        = a & m;
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
            p[FlagC] = a[7];
         end
         ACT_ASR: begin
            t        = a & m;
            p[FlagC] = t[0];
            a        = {1'b0, t[7:1]};
            p[FlagN] = 1'b0;
            p[FlagZ] = (a == 8'd0);
         end
         ACT_ARR: begin
            t        = a & m;
            a        = {p[FlagC], t[7:1]};
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
            if (bcd) begin
               p[FlagV] = t[6] ^ a[6];
               if (({1'b0, t[3:0]} + {4'd0, t[0]}) > 5'd5) begin
                  a[3:0] = a[3:0] + 4'd6;
               end
               if (({1'b0, t[7:4]} + {4'd0, t[4]}) > 5'd5) begin
                  a        = a + 8'h60;
                  p[FlagC] = 1'b1;
               end else begin
                  p[FlagC] = 1'b0;
               end
            end else begin
               p[FlagC] = a[6];
               p[FlagV] = a[6] ^ a[5];
            end
         end
         ACT_SBX: begin
            t        = a & x;
            x        = t - m;
            p[FlagC] = (t >= m);
            p[FlagN] = x[7];
            p[FlagZ] = (x == 8'd0);
         end
         ACT_LAS: begin
            v        = m & sp;
            a        = v;
            x        = v;
            sp       = v;
            p[FlagN] = v[7];
            p[FlagZ] = (v == 8'd0);
         end
         ACT_ANE: begin
            a        = (a | MagicConst) & x & m;
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
         end
         ACT_LXA: begin
            a        = (a | MagicConst) & m;
            x        = a;
            p[FlagN] = a[7];
            p[FlagZ] = (a == 8'd0);
         end
         ACT_SHA: begin
            we = 1'b1;
            wd = a & x & hi;
         end
         ACT_SHX: begin
            we = 1'b1;
            wd = x & hi;
         end
         ACT_SHY: begin
            we = 1'b1;
            wd = req_word.yreg & hi;
         end
         ACT_SHS: begin
            sp = a & x;
            we = 1'b1;
            wd = a & x & hi;
         end
         ACT_JAM: begin
            halt = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_word.acc_out      = a;
      rsp_word.x_out        = x;
      rsp_word.sp_out       = sp;
      rsp_word.status_out   = p;
      rsp_word.write_enable = we;
      rsp_word.write_data   = we ? wd : 8'd0;
      rsp_word.halted       = halt;
   end

endmodule

FILE: dv/undocumented_opcode_execute_core_test.sv
module undocumented_opcode_execute_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import uoe_pkg::*;

   localparam logic [4:0] UnusedAction = 5'd31;
   localparam int CycleLimit = 200000;

   typedef struct packed {
      uoe_req_type word;
      logic        given;
      uoe_rsp_type result;
   } directed_row_type;

   typedef struct {
      bit          given;
      uoe_rsp_type result;
   } given_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   uoe_req_if req_chan();
   uoe_rsp_if rsp_chan();

   undocumented_opcode_execute_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bit               bcd_enabled = 1'b1;
   int               send_idle_pct = 21;
   int               recv_stall_pct = 75;
   int               errors = 0;
   int               cycle_count = 0;
   given_result_type given_q[$];
   uoe_rsp_type      expected_q[$];

   // Rows with a typed-in result are checked against it; the rest go through the predictor.
   directed_row_type directed_rows [0:24] = '{
      '{'{ACT_LAX, 8'h12, 8'h34, 8'h00, 8'hFD, 8'h00, 8'h00, 16'h0000}, 1'b1,
        '{8'h00, 8'h00, 8'hFD, 8'h02, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_LAX, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h02, 8'hFF, 16'hFFFF}, 1'b1,
        '{8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_SAX, 8'hFF, 8'h0F, 8'h00, 8'hFF, 8'hFF, 8'h00, 16'h1234}, 1'b1,
        '{8'hFF, 8'h0F, 8'hFF, 8'hFF, 1'b1, 8'h0F, 1'b0}},
      '{'{ACT_DCP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0}},
      '{'{ACT_ISB, 8'h50, 8'h00, 8'h00, 8'h00, 8'h01, 8'h0F, 16'h0000}, 1'b0, '0},
      '{'{ACT_ISB, 8'h50, 8'h00, 8'h00, 8'h00, 8'h09, 8'h0F, 16'h0000}, 1'b0, '0},
      '{'{ACT_SLO, 8'h00, 8'h11, 8'h22, 8'h33, 8'h00, 8'h80, 16'h0000}, 1'b1,
        '{8'h00, 8'h11, 8'h33, 8'h03, 1'b1, 8'h00, 1'b0}},
      '{'{ACT_RLA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 16'h0000}, 1'b0, '0},
      '{'{ACT_SRE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 16'h0000}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h03, 1'b1, 8'h00, 1'b0}},
      '{'{ACT_RRA, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 16'h0000}, 1'b0, '0},
      '{'{ACT_RRA, 8'h99, 8'h00, 8'h00, 8'h00, 8'h09, 8'h03, 16'h0000}, 1'b0, '0},
      '{'{ACT_ANC, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 16'h0000}, 1'b1,
        '{8'h80, 8'h00, 8'h00, 8'h81, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_ASR, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 16'h0000}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h03, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_ARR, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 16'h0000}, 1'b0, '0},
      '{'{ACT_ARR, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h09, 8'hFF, 16'h0000}, 1'b0, '0},
      '{'{ACT_SBX, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000}, 1'b1,
        '{8'hFF, 8'h00, 8'h00, 8'h03, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_LAS, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h00, 8'hFF, 16'h0000}, 1'b1,
        '{8'h5A, 8'h5A, 8'h5A, 8'h00, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_ANE, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000}, 1'b1,
        '{8'hEE, 8'hFF, 8'h00, 8'h80, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_LXA, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000}, 1'b1,
        '{8'hEF, 8'hEF, 8'h00, 8'h80, 1'b0, 8'h00, 1'b0}},
      '{'{ACT_SHA, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF}, 1'b1,
        '{8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0}},
      '{'{ACT_SHX, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h12FF}, 1'b1,
        '{8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h13, 1'b0}},
      '{'{ACT_SHY, 8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00, 16'h7E00}, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h70, 1'b0}},
      '{'{ACT_SHS, 8'hF0, 8'h3C, 8'h00, 8'hAA, 8'h00, 8'h00, 16'h0000}, 1'b1,
        '{8'hF0, 8'h3C, 8'h30, 8'h00, 1'b1, 8'h00, 1'b0}},
      '{'{ACT_JAM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1,
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b1}},
      '{'{UnusedAction, 8'hA5, 8'h5A, 8'h00, 8'h80, 8'hC3, 8'h3C, 16'h8000}, 1'b1,
        '{8'hA5, 8'h5A, 8'h80, 8'hC3, 1'b0, 8'h00, 1'b0}}
   };

   function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q = p;
      q[FlagN] = v[7];
      q[FlagZ] = (v == 8'h00);
      return q;
   endfunction

   function automatic uoe_rsp_type execute_undoc(input uoe_req_type w, input bit dec_on);
      logic [7:0]  a, x, sp, p, m, v, t, hi, wd;
      logic        we, halt, bcd;
      int          ia, iv, ic, it, bin, lo, d;
      uoe_rsp_type r;
      a = w.acc;
      x = w.xreg;
      sp = w.stack_ptr;
      p = w.status;
      m = w.operand;
      hi = w.addr[15:8] + 8'd1;
      bcd = dec_on && w.status[FlagD];
      we = 1'b0;
      wd = 8'h00;
      halt = 1'b0;
      case (w.action)
         ACT_LAX: begin
            a = m;
            x = m;
            p = with_nz(p, m);
         end
         ACT_SAX: begin
            we = 1'b1;
            wd = a & x;
         end
         ACT_DCP: begin
            v = m - 8'd1;
            we = 1'b1;
            wd = v;
            p[FlagC] = (a >= v);
            p = with_nz(p, a - v);
         end
         ACT_ISB: begin
            v = m + 8'd1;
            we = 1'b1;
            wd = v;
            ia = a;
            iv = v;
            ic = p[FlagC];
            bin = (ia - iv - (1 - ic)) & 511;
            a = bin[7:0];
            p = with_nz(p, bin[7:0]);
            p[FlagC] = (ia + ic) > iv;
            p[FlagV] = ((ia ^ iv) & (ia ^ bin) & 128) != 0;
            if (bcd) begin
               lo = (ia & 15) - (iv & 15) + ic - 1;
               if (lo < 0) begin
                  d = (ia & 240) - (iv & 240) + ((lo - 6) & 15) - 16;
               end else begin
                  d = (ia & 240) - (iv & 240) + lo;
               end
               if (d < 0) begin
                  d = d - 96;
               end
               a = d[7:0];
            end
         end
         ACT_SLO: begin
            p[FlagC] = m[7];
            v = {m[6:0], 1'b0};
            we = 1'b1;
            wd = v;
            a = a | v;
            p = with_nz(p, a);
         end
         ACT_RLA: begin
            v = {m[6:0], p[FlagC]};
            p[FlagC] = m[7];
            we = 1'b1;
            wd = v;
            a = a & v;
            p = with_nz(p, a);
         end
         ACT_SRE: begin
            p[FlagC] = m[0];
            v = {1'b0, m[7:1]};
            we = 1'b1;
            wd = v;
            a = a ^ v;
            p = with_nz(p, a);
         end
         ACT_RRA: begin
            v = {p[FlagC], m[7:1]};
            p[FlagC] = m[0];
            we = 1'b1;
            wd = v;
            ia = a;
            iv = v;
            ic = p[FlagC];
            bin = ia + iv + ic;
            if (!bcd) begin
               a = bin[7:0];
               p = with_nz(p, a);
               p[FlagC] = bin > 255;
               p[FlagV] = (~(ia ^ iv) & (ia ^ bin) & 128) != 0;
            end else begin
               lo = (ia & 15) + (iv & 15) + ic;
               if (lo >= 10) begin
                  lo = ((lo + 6) & 15) + 16;
               end
               d = (ia & 240) + (iv & 240) + lo;
               p[FlagZ] = (bin & 255) == 0;
               p[FlagN] = d[7];
               p[FlagV] = (~(ia ^ iv) & (ia ^ d) & 128) != 0;
               if (d >= 160) begin
                  d = d + 96;
               end
               p[FlagC] = d >= 256;
               a = d[7:0];
            end
         end
         ACT_ANC: begin
            a = a & m;
            p = with_nz(p, a);
            p[FlagC] = a[7];
         end
         ACT_ASR: begin
            a = a & m;
            p[FlagC] = a[0];
            a = {1'b0, a[7:1]};
            p = with_nz(p, a);
         end
         ACT_ARR: begin
            t = a & m;
            it = t;
            a = {p[FlagC], t[7:1]};
            p = with_nz(p, a);
            if (bcd) begin
               p[FlagV] = t[6] ^ a[6];
               if ((it & 15) + (it & 1) > 5) begin
                  a = {a[7:4], a[3:0] + 4'd6};
               end
               if ((it & 240) + (it & 16) > 80) begin
                  a = a + 8'h60;
                  p[FlagC] = 1'b1;
               end else begin
                  p[FlagC] = 1'b0;
               end
            end else begin
               p[FlagC] = a[6];
               p[FlagV] = a[6] ^ a[5];
            end
         end
         ACT_SBX: begin
            t = a & x;
            x = t - m;
            p[FlagC] = (t >= m);
            p = with_nz(p, x);
         end
         ACT_LAS: begin
            v = m & sp;
            a = v;
            x = v;
            sp = v;
            p = with_nz(p, v);
         end
         ACT_ANE: begin
            a = (a | MagicConst) & x & m;
            p = with_nz(p, a);
         end
         ACT_LXA: begin
            a = (a | MagicConst) & m;
            x = a;
            p = with_nz(p, a);
         end
         ACT_SHA: begin
            we = 1'b1;
            wd = a & x & hi;
         end
         ACT_SHX: begin
            we = 1'b1;
            wd = x & hi;
         end
         ACT_SHY: begin
            we = 1'b1;
            wd = w.yreg & hi;
         end
         ACT_SHS: begin
            sp = a & x;
            we = 1'b1;
            wd = sp & hi;
         end
         ACT_JAM: begin
            halt = 1'b1;
         end
         default: begin
         end
      endcase
      r.acc_out = a;
      r.x_out = x;
      r.sp_out = sp;
      r.status_out = p;
      r.write_enable = we;
      r.write_data = we ? wd : 8'h00;
      r.halted = halt;
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return {4'($urandom_range(9)), 4'($urandom_range(9))};
         3: return {4'($urandom_range(9)), 4'($urandom_range(9))};
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic send_word(input uoe_req_type word, input bit given,
                            input uoe_rsp_type result);
      given_result_type g;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      g.given = given;
      g.result = result;
      given_q.push_back(g);
      req_chan.valid <= 1'b1;
      req_chan.data <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      uoe_req_type w;
      repeat (count) begin
         if ($urandom_range(9) == 0) begin
            w.action = 5'($urandom_range(31, 20));
         end else begin
            w.action = 5'($urandom_range(19));
         end
         w.acc = pick_byte();
         w.xreg = pick_byte();
         w.yreg = pick_byte();
         w.stack_ptr = pick_byte();
         w.status = 8'($urandom);
         w.operand = pick_byte();
         w.addr = {pick_byte(), 8'($urandom)};
         send_word(w, 1'b0, '0);
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_decimal_enable(input bit value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bcd_enabled = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      given_result_type g;
      uoe_rsp_type      want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t unexpected response word, actual %h", $time, rsp_chan.data);
            end else begin
               want = expected_q.pop_front();
               check_field("acc_out", want.acc_out, rsp_chan.data.acc_out);
               check_field("x_out", want.x_out, rsp_chan.data.x_out);
               check_field("sp_out", want.sp_out, rsp_chan.data.sp_out);
               check_field("status_out", want.status_out, rsp_chan.data.status_out);
               check_field("write_enable", 8'(want.write_enable),
                           8'(rsp_chan.data.write_enable));
               check_field("write_data", want.write_data, rsp_chan.data.write_data);
               check_field("halted", 8'(want.halted), 8'(rsp_chan.data.halted));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            g = given_q.pop_front();
            if (g.given) begin
               expected_q.push_back(g.result);
            end else begin
               expected_q.push_back(execute_undoc(req_chan.data, bcd_enabled));
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].given, directed_rows[i].result);
      end
      send_random(420);
      drain_results();
      write_decimal_enable(1'b0);
      send_idle_pct = 75;
      recv_stall_pct = 21;
      send_random(430);
      drain_results();
      write_decimal_enable(1'b1);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random(440);
      drain_results();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/uoe_pkg.sv
sv/uoe_req_if.sv
sv/uoe_rsp_if.sv
sv/uoe_alu.sv
sv/undocumented_opcode_execute_core.sv
dv/undocumented_opcode_execute_core_test.sv
